@@ sv/bhpq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the binary min-heap priority queue.
// No dependencies; used by every module of the block.
package bhpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int PRIO_W          = 16;
  localparam int TAG_W           = 16;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 7;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // compare unit selection codes
  localparam logic [1:0] PICK_NODE = 2'd0;
  localparam logic [1:0] PICK_C1   = 2'd1;
  localparam logic [1:0] PICK_C2   = 2'd2;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic                     command;
    logic signed [PRIO_W-1:0] priority_req;
    logic        [TAG_W-1:0]  payload_tag;
  } req_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [PRIO_W-1:0]   out_priority;
    logic        [TAG_W-1:0]    out_payload_tag;
    logic        [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // operands for the shared compare unit
  typedef struct packed {
    logic signed [PRIO_W-1:0] node_prio;
    logic                     c1_valid;
    logic signed [PRIO_W-1:0] c1_prio;
    logic                     c2_valid;
    logic signed [PRIO_W-1:0] c2_prio;
  } cmp_req_t;

endpackage

@@ sv/binary_min_heap_priority_queue_core.sv @@
`timescale 1ns / 1ps
// Binary min-heap priority queue, one transaction at a time; each heap level
// takes a registered RAM read state, then a compare/write state. Full/empty
// results go straight to the finish state; enqueue climbs, dequeue reads root
// and last slot, lifts the last entry and sinks it. A request is accepted only
// once the last result is in the output register, which a stalled receiver
// holds off. Sync active-high reset empties the heap and clears rsp_valid.
module binary_min_heap_priority_queue_core #(
  parameter int QUEUE_DEPTH = bhpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bhpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bhpq_pkg::rsp_t rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);      // slot index width
  localparam int CW = $clog2(QUEUE_DEPTH + 1);  // entry count width
  localparam int IW = AW + 2;                   // child index width, no overflow

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;  // read parent of hole
  localparam logic [2:0] S_UP_CMP  = 3'd2;  // compare new entry with parent
  localparam logic [2:0] S_DQ_RD   = 3'd3;  // read root and last slot
  localparam logic [2:0] S_DQ_HEAD = 3'd4;  // capture root, lift last entry
  localparam logic [2:0] S_DN_RD   = 3'd5;  // read both children of hole
  localparam logic [2:0] S_DN_CMP  = 3'd6;  // pick smallest of entry and kids
  localparam logic [2:0] S_FIN     = 3'd7;  // hand result to output register

  logic [2:0]                    state;
  logic [CW-1:0]                 cnt;       // entries held
  logic [AW-1:0]                 pos;       // current hole position
  bhpq_pkg::entry_t              elem;      // entry being sifted
  logic [bhpq_pkg::STATUS_W-1:0] res_status;
  logic signed [bhpq_pkg::PRIO_W-1:0] res_prio;
  logic [bhpq_pkg::TAG_W-1:0]    res_tag;

  // RAM ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  bhpq_pkg::entry_t mem_wdata;
  logic [AW-1:0]    mem_raddr0;
  logic [AW-1:0]    mem_raddr1;
  bhpq_pkg::entry_t mem_rdata0;
  bhpq_pkg::entry_t mem_rdata1;

  // index arithmetic
  logic [AW-1:0] pos_dec;
  logic [AW-1:0] parent;
  logic [CW-1:0] cnt_dec;
  logic [IW-1:0] lidx;
  logic [IW-1:0] ridx;
  logic          l_ok;
  logic          r_ok;

  // shared compare unit
  bhpq_pkg::cmp_req_t cmp_op;
  logic [1:0]         cmp_pick;

  logic req_fire;
  logic rsp_load;

  assign pos_dec = pos - AW'(1);
  assign parent  = pos_dec >> 1;
  assign cnt_dec = cnt - CW'(1);
  assign lidx    = ({2'b00, pos} << 1) + IW'(1);
  assign ridx    = ({2'b00, pos} << 1) + IW'(2);
  assign l_ok    = lidx < IW'(cnt);
  assign r_ok    = ridx < IW'(cnt);

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_load  = (state == S_FIN) && (!rsp_valid || rsp_ready);

  bhpq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

  // Sift up: node is the parent, the rising entry is the only candidate.
  // Sift down: node is the sinking entry, candidates are the two children.
  always_comb begin
    if (state == S_UP_CMP) begin
      cmp_op.node_prio = mem_rdata0.prio;
      cmp_op.c1_valid  = 1'b1;
      cmp_op.c1_prio   = elem.prio;
      cmp_op.c2_valid  = 1'b0;
      cmp_op.c2_prio   = elem.prio;
    end else begin
      cmp_op.node_prio = elem.prio;
      cmp_op.c1_valid  = l_ok;
      cmp_op.c1_prio   = mem_rdata0.prio;
      cmp_op.c2_valid  = r_ok;
      cmp_op.c2_prio   = mem_rdata1.prio;
    end
  end

  bhpq_cmp u_cmp (
    .op   (cmp_op),
    .pick (cmp_pick)
  );

  // RAM addressing and hole writes
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pos;
    mem_wdata  = elem;
    mem_raddr0 = parent;
    mem_raddr1 = parent;
    case (state)
      S_UP_RD: begin
        mem_we = (pos == '0);
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_pick == bhpq_pkg::PICK_C1) begin
          mem_wdata = mem_rdata0;  // parent moves down into the hole
        end
      end
      S_DQ_RD: begin
        mem_raddr0 = '0;
        mem_raddr1 = cnt_dec[AW-1:0];
      end
      S_DN_RD: begin
        mem_we     = !l_ok;
        mem_raddr0 = lidx[AW-1:0];
        mem_raddr1 = ridx[AW-1:0];
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (cmp_pick == bhpq_pkg::PICK_C1) begin
          mem_wdata = mem_rdata0;
        end else if (cmp_pick == bhpq_pkg::PICK_C2) begin
          mem_wdata = mem_rdata1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            res_status <= bhpq_pkg::ST_OK;
            res_prio   <= '0;
            res_tag    <= '0;
            if (req.command == bhpq_pkg::CMD_ENQ) begin
              if (cnt == CW'(QUEUE_DEPTH)) begin
                res_status <= bhpq_pkg::ST_FULL;
                state      <= S_FIN;
              end else begin
                elem.prio <= req.priority_req;
                elem.tag  <= req.payload_tag;
                pos       <= cnt[AW-1:0];
                cnt       <= cnt + CW'(1);
                state     <= S_UP_RD;
              end
            end else begin
              if (cnt == '0) begin
                res_status <= bhpq_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                state <= S_DQ_RD;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (cmp_pick == bhpq_pkg::PICK_C1) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DQ_RD: begin
          state <= S_DQ_HEAD;
        end
        S_DQ_HEAD: begin
          res_prio <= mem_rdata0.prio;
          res_tag  <= mem_rdata0.tag;
          elem     <= mem_rdata1;
          pos      <= '0;
          cnt      <= cnt_dec;
          state    <= (cnt_dec == '0) ? S_FIN : S_DN_RD;
        end
        S_DN_RD: begin
          state <= l_ok ? S_DN_CMP : S_FIN;
        end
        S_DN_CMP: begin
          if (cmp_pick == bhpq_pkg::PICK_C1) begin
            pos   <= lidx[AW-1:0];
            state <= S_DN_RD;
          end else if (cmp_pick == bhpq_pkg::PICK_C2) begin
            pos   <= ridx[AW-1:0];
            state <= S_DN_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: a finished result waits here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status          <= res_status;
      rsp.out_priority    <= res_prio;
      rsp.out_payload_tag <= res_tag;
      rsp.entry_count     <= bhpq_pkg::COUNT_W'(cnt);
    end
  end

endmodule

@@ sv/bhpq_ram.sv @@
`timescale 1ns / 1ps
// Heap entry store: one write port, two registered read ports.
// Depends on bhpq_pkg for the entry type.
module bhpq_ram #(
  parameter int DEPTH = bhpq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  bhpq_pkg::entry_t      wdata,
  input  logic [AW-1:0]         raddr0,
  input  logic [AW-1:0]         raddr1,
  output bhpq_pkg::entry_t      rdata0,
  output bhpq_pkg::entry_t      rdata1
);

  bhpq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ sv/bhpq_cmp.sv @@
`timescale 1ns / 1ps
// Shared priority compare: picks the smallest of a node and up to two
// candidates, strict less-than, first candidate tested first. Uses bhpq_pkg.
module bhpq_cmp (
  input  bhpq_pkg::cmp_req_t op,
  output logic [1:0]         pick
);

  logic signed [bhpq_pkg::PRIO_W-1:0] best_prio;

  always_comb begin
    pick      = bhpq_pkg::PICK_NODE;
    best_prio = op.node_prio;
    if (op.c1_valid && (op.c1_prio < best_prio)) begin
      pick      = bhpq_pkg::PICK_C1;
      best_prio = op.c1_prio;
    end
    if (op.c2_valid && (op.c2_prio < best_prio)) begin
      pick = bhpq_pkg::PICK_C2;
    end
  end

endmodule

@@ sv/bhpq_chk.sv @@
`timescale 1ns / 1ps
// Port-level checks for the heap priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_min_heap_priority_queue_core.
module bhpq_chk #(
  parameter int QUEUE_DEPTH = bhpq_pkg::QUEUE_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input bhpq_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input bhpq_pkg::rsp_t rsp
);

  // one transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a second transaction while busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == bhpq_pkg::ST_FULL)
      |-> rsp.entry_count == bhpq_pkg::COUNT_W'(QUEUE_DEPTH))
    else $error("full status without a full heap");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == bhpq_pkg::ST_EMPTY)
      |-> (rsp.entry_count == '0) && (rsp.out_priority == '0)
          && (rsp.out_payload_tag == '0))
    else $error("empty status with entries or data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind binary_min_heap_priority_queue_core bhpq_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_bhpq_chk (.*);

@@ tb/bhpq_heap_checker.sv @@
`timescale 1ns / 1ps
// Response checker for binary_min_heap_priority_queue_core: keeps a shadow heap.
// Depends on bhpq_pkg for the request/response types and the codes.
module bhpq_heap_checker #(
  parameter int QUEUE_DEPTH = bhpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  bhpq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  bhpq_pkg::rsp_t rsp,
  output int             fail_count,
  output int             outstanding,
  output int             checked,
  output int             full_hits,
  output int             empty_hits
);

  // shadow heap: priorities and tags of the entries held
  int          shadow_prio [QUEUE_DEPTH];
  logic [15:0] shadow_tag  [QUEUE_DEPTH];
  int          shadow_fill;

  bhpq_pkg::rsp_t due_rsp [$];
  int   fails, seen, n_full, n_empty;

  initial begin
    shadow_fill = 0;
    fails       = 0;
    seen        = 0;
    n_full      = 0;
    n_empty     = 0;
  end

  function automatic void swap_slots(input int a, input int b);
    int          p;
    logic [15:0] t;
    p = shadow_prio[a];
    t = shadow_tag[a];
    shadow_prio[a] = shadow_prio[b];
    shadow_tag[a]  = shadow_tag[b];
    shadow_prio[b] = p;
    shadow_tag[b]  = t;
  endfunction

  // apply one command to the shadow heap and return the response it yields
  function automatic bhpq_pkg::rsp_t heap_apply(input bhpq_pkg::req_t r);
    bhpq_pkg::rsp_t res;
    int   pos, up, lc, rc, best;
    bit   moving;
    res = '0;
    res.status = bhpq_pkg::ST_OK;
    if (r.command == bhpq_pkg::CMD_ENQ) begin
      if (shadow_fill >= QUEUE_DEPTH) begin
        res.status = bhpq_pkg::ST_FULL;
        n_full++;
      end else begin
        shadow_prio[shadow_fill] = $signed(r.priority_req);
        shadow_tag[shadow_fill]  = r.payload_tag;
        pos = shadow_fill;
        shadow_fill++;
        moving = 1'b1;
        // sift up, strict less-than
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_prio[pos] < shadow_prio[up]) begin
            swap_slots(pos, up);
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else begin
      if (shadow_fill == 0) begin
        res.status = bhpq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        res.out_priority    = shadow_prio[0][15:0];
        res.out_payload_tag = shadow_tag[0];
        shadow_prio[0] = shadow_prio[shadow_fill - 1];
        shadow_tag[0]  = shadow_tag[shadow_fill - 1];
        shadow_fill--;
        pos = 0;
        moving = 1'b1;
        // sift down, left child wins ties
        while (moving) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          best = pos;
          if (lc < shadow_fill && shadow_prio[lc] < shadow_prio[best]) best = lc;
          if (rc < shadow_fill && shadow_prio[rc] < shadow_prio[best]) best = rc;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    res.entry_count = shadow_fill[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    bhpq_pkg::rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) due_rsp.push_back(heap_apply(req));
      if (rsp_valid && rsp_ready) begin
        seen++;
        if (due_rsp.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t: response with none outstanding: st=%0d prio=%0d tag=%h cnt=%0d",
                     $time, rsp.status, $signed(rsp.out_priority), rsp.out_payload_tag,
                     rsp.entry_count);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status || rsp.out_priority !== want.out_priority ||
              rsp.out_payload_tag !== want.out_payload_tag ||
              rsp.entry_count !== want.entry_count) begin
            fails++;
            if (fails <= 10)
              $display("%t: mismatch st/prio/tag/cnt exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                       $time, want.status, $signed(want.out_priority), want.out_payload_tag,
                       want.entry_count, rsp.status, $signed(rsp.out_priority),
                       rsp.out_payload_tag, rsp.entry_count);
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= due_rsp.size();
    checked     <= seen;
    full_hits   <= n_full;
    empty_hits  <= n_empty;
  end

endmodule

@@ tb/binary_min_heap_priority_queue_core_test.sv @@
`timescale 1ns / 1ps
// Top of the testbench for binary_min_heap_priority_queue_core: stimulus and verdict.
// Depends on bhpq_pkg, the core RTL and bhpq_heap_checker.
module binary_min_heap_priority_queue_core_test;

  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_AT      = 150;  // response index where the receiver stalls long
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000; // cycles with no transaction on either channel
  localparam int DRAIN_WAIT   = 40;   // well above the worst-case core latency

  // how the priorities of enqueued entries are spread
  typedef enum int {SPREAD_FULL, SPREAD_TIGHT, SPREAD_EDGES} spread_t;
  // bias of a stretch of random commands
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  bhpq_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  bhpq_pkg::rsp_t rsp;

  int fail_count, outstanding, checked, full_hits, empty_hits;
  int commands_sent;
  int idle_cycles;
  bit send_burst;

  binary_min_heap_priority_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bhpq_heap_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .full_hits   (full_hits),
    .empty_hits  (empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  // The longest legal quiet stretch is the receiver hold, well under the limit.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("** binary_min_heap_priority_queue_core: FAILED **");
        $finish;
      end
    end
  end

  // Priority source for a given spread. The tight spread makes lots of
  // ties so the left-child and strict-compare rules get exercised.
  function automatic logic [15:0] draw_prio(input spread_t spread);
    logic [15:0] p;
    case (spread)
      SPREAD_FULL:  p = 16'($urandom);
      SPREAD_TIGHT: p = 16'($urandom_range(0, 8) - 4);
      default: begin
        case ($urandom_range(0, 6))
          0:       p = 16'h8000;
          1:       p = 16'h8001;
          2:       p = 16'hFFFF;
          3:       p = 16'h0000;
          4:       p = 16'h0001;
          5:       p = 16'h7FFE;
          default: p = 16'h7FFF;
        endcase
      end
    endcase
    return p;
  endfunction

  // Offer one command; entered and left at a falling edge. Valid stays high
  // across back-to-back transactions (gap of zero) so it is never lowered and
  // raised in the same step.
  task automatic push_cmd(input logic cmd, input logic [15:0] p, input logic [15:0] t);
    int             gap;
    bhpq_pkg::req_t item;
    // bursts of zero gap now and then
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.command      = cmd;
    item.priority_req = p;
    item.payload_tag  = t;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    commands_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls per response, zero-stall bursts, and one long
  // hold so the core backs up and drops req_ready while the sender waits.
  initial begin
    int  gap;
    int  taken;
    bit  burst;
    rsp_ready = 1'b0;
    taken = 0;
    burst = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 15) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int      sent_random;
    int      phase_idx;
    int      len;
    int      deq_pct;
    phase_t  kind;
    spread_t spread;
    logic    cmd;

    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    commands_sent = 0;
    send_burst    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: dequeue on empty, priority extremes, ties at min and mid, tags
    // all-zero and all-one, a drain past empty, then a tie at max drained again.
    push_cmd(bhpq_pkg::CMD_DEQ, 16'h0000, 16'h0000);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'd100,  16'h0001);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'h7FFF, 16'hFFFF);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'h8000, 16'h0000);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'h0000, 16'h5555);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'hFFFF, 16'hAAAA);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'd100,  16'h0002);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'd100,  16'h0003);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'h8000, 16'h1234);
    repeat (9) push_cmd(bhpq_pkg::CMD_DEQ, 16'hFFFF, 16'hFFFF);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'h7FFF, 16'h00FF);
    push_cmd(bhpq_pkg::CMD_ENQ, 16'h7FFF, 16'hFF00);
    repeat (2) push_cmd(bhpq_pkg::CMD_DEQ, 16'h0000, 16'h0000);

    // Random: first a pure fill (guaranteed to hit full) and a pure drain
    // (guaranteed to hit empty), then a mix of phases.
    sent_random = 0;
    phase_idx   = 0;
    while (sent_random < RANDOM_ITEMS) begin
      if (phase_idx == 0) kind = PH_FILL;
      else if (phase_idx == 1) kind = PH_DRAIN;
      else begin
        case ($urandom_range(0, 5))
          0:       kind = PH_FILL;
          1:       kind = PH_DRAIN;
          default: kind = PH_MIXED;
        endcase
      end
      spread = spread_t'($urandom_range(0, 2));
      case (kind)
        PH_FILL: begin
          len = 72;
          deq_pct = 0;
        end
        PH_DRAIN: begin
          len = 72;
          deq_pct = 100;
        end
        default: begin
          len = $urandom_range(20, 60);
          deq_pct = 25 * $urandom_range(1, 3);
        end
      endcase
      for (int i = 0; i < len && sent_random < RANDOM_ITEMS; i++) begin
        cmd = ($urandom_range(1, 100) <= deq_pct) ? bhpq_pkg::CMD_DEQ : bhpq_pkg::CMD_ENQ;
        push_cmd(cmd, draw_prio(spread), 16'($urandom));
        sent_random++;
      end
      phase_idx++;
    end
    req_valid <= 1'b0;

    // wait out every outstanding response, then a few latencies more
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Ran %0d commands, %0d responses checked against the shadow heap.",
             commands_sent, checked);
    $display("Full rejections: %0d, empty dequeues: %0d, mismatches: %0d.",
             full_hits, empty_hits, fail_count);
    if (fail_count == 0 && outstanding == 0)
      $display("** binary_min_heap_priority_queue_core: PASSED **");
    else
      $display("** binary_min_heap_priority_queue_core: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bhpq_pkg.sv
sv/bhpq_ram.sv
sv/bhpq_cmp.sv
sv/binary_min_heap_priority_queue_core.sv
sv/bhpq_chk.sv
tb/bhpq_heap_checker.sv
tb/binary_min_heap_priority_queue_core_test.sv
